@@ rtl/ptw_pkg.sv @@
// Shared types, codes and a helper function for the page table walker.
package ptw_pkg;

    localparam int VA_W   = 48;
    localparam int PA_W   = 64;
    localparam int IDX_W  = 9;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } result_kind_t;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        LVL_TOP  = 2'd0,
        LVL_DIR  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_LEAF = 2'd3
    } level_t;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        op_t              op;
        logic [VA_W-1:0]  vaddr;
        logic [PA_W-1:0]  data;
        logic             present;
        logic             large_page;
    } walk_item_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input level_t lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_TOP:  idx = va[47:39];
            LVL_DIR:  idx = va[38:30];
            LVL_MID:  idx = va[29:21];
            LVL_LEAF: idx = va[20:12];
            default:  idx = va[47:39];
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/ptw_ifs.sv @@
// Valid/ready channel interfaces for walker items and walker results.
interface ptw_req_if
    import ptw_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [VA_W-1:0] virt_addr;
    logic [PA_W-1:0] mem_data;

    modport source (output valid, output req_type, output virt_addr, output mem_data,
                    input ready);
    modport sink   (input valid, input req_type, input virt_addr, input mem_data,
                    output ready);
endinterface

interface ptw_res_if
    import ptw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [PA_W-1:0]   out_addr;

    modport source (output valid, output result_kind, output out_addr, input ready);
    modport sink   (input valid, input result_kind, input out_addr, output ready);
endinterface

@@ rtl/ptw_front.sv @@
// Front end: classifies incoming items and queues them for the walker.
module ptw_front
    import ptw_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    ptw_req_if.sink      req,
    output logic         q_valid,
    output walk_item_t   q_item,
    input  logic         q_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    walk_item_t          store_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    walk_item_t          in_item;
    logic                push;

    always_comb
    begin
        in_item.op         = req.req_type ? OP_RESPONSE : OP_TRANSLATE;
        in_item.vaddr      = req.virt_addr;
        in_item.data       = req.mem_data;
        in_item.present    = req.mem_data[ENTRY_PRESENT_BIT];
        in_item.large_page = req.mem_data[ENTRY_LARGE_BIT];
    end

    assign req.ready = (count_reg != CW'(DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/ptw_back.sv @@
// Back end: walk state machine, entry address adder and result register.
module ptw_back
    import ptw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [PA_W-1:0] root_base,
    input  logic            q_valid,
    input  walk_item_t      q_item,
    output logic            q_pop,
    ptw_res_if.source       res
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_L0   = 5'b00010,
        ST_L1   = 5'b00100,
        ST_L2   = 5'b01000,
        ST_L3   = 5'b10000
    } walk_state_t;

    walk_state_t        state_reg, state_next;
    logic [VA_W-1:0]    vaddr_reg, vaddr_next;
    logic               res_valid_reg;
    result_kind_t       kind_reg, kind_next;
    logic [PA_W-1:0]    addr_reg, addr_next;
    logic               emit;
    logic               take;
    level_t             next_level;
    logic [PA_W-1:0]    add_base;
    logic [IDX_W-1:0]   add_idx;
    logic [PA_W-1:0]    read_addr;

    assign take  = q_valid && (!res_valid_reg || res.ready);
    assign q_pop = take;

    always_comb
    begin
        if (q_item.op == OP_TRANSLATE)
        begin
            add_base = root_base;
            add_idx  = level_index(q_item.vaddr, LVL_TOP);
        end
        else
        begin
            unique case (state_reg)
                ST_L0:   next_level = LVL_DIR;
                ST_L1:   next_level = LVL_MID;
                default: next_level = LVL_LEAF;
            endcase
            add_base = {q_item.data[PA_W-1:12], 12'b0};
            add_idx  = level_index(vaddr_reg, next_level);
        end
        if (q_item.op == OP_TRANSLATE)
        begin
            next_level = LVL_TOP;
        end
    end

    assign read_addr = add_base + {{(PA_W - IDX_W - 3){1'b0}}, add_idx, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        vaddr_next = vaddr_reg;
        emit       = 1'b0;
        kind_next  = KIND_READ;
        addr_next  = read_addr;
        if (q_item.op == OP_TRANSLATE)
        begin
            state_next = ST_L0;
            vaddr_next = q_item.vaddr;
            emit       = 1'b1;
        end
        else if (state_reg != ST_IDLE)
        begin
            emit = 1'b1;
            priority if (!q_item.present)
            begin
                state_next = ST_IDLE;
                kind_next  = KIND_FAULT;
                addr_next  = '0;
            end
            else if (state_reg == ST_L2 && q_item.large_page)
            begin
                state_next = ST_IDLE;
                kind_next  = KIND_DONE;
                addr_next  = {q_item.data[PA_W-1:21], vaddr_reg[20:0]};
            end
            else if (state_reg == ST_L3)
            begin
                state_next = ST_IDLE;
                kind_next  = KIND_DONE;
                addr_next  = {q_item.data[PA_W-1:12], vaddr_reg[11:0]};
            end
            else
            begin
                unique case (state_reg)
                    ST_L0:   state_next = ST_L1;
                    ST_L1:   state_next = ST_L2;
                    default: state_next = ST_L3;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vaddr_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
                vaddr_reg <= vaddr_next;
            end
            if (take && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.result_kind = kind_reg;
    assign res.out_addr    = addr_reg;

endmodule

@@ rtl/four_level_page_table_walker.sv @@
// Top level of the four-level page table walker.
//
//  Channel  Role    Transfer contents
//  req      sink    req_type, virt_addr, mem_data
//  res      source  result_kind, out_addr
//  cfg      write   root_base_reg via cfg_we / cfg_wdata
//
// One item per cycle while the result port is not stalled; each accepted item
// waits in the queue before the back takes it, and the back registers any result.
// The queue between the front and the back holds QUEUE_DEPTH items.
// A stalled result port stops the back; the front keeps taking items until
// the queue is full. Reset clears the queue, the walk state and the result.
module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    ptw_req_if.sink         req,
    ptw_res_if.source       res,
    input  logic            cfg_we,
    input  logic [PA_W-1:0] cfg_wdata
);

    logic [PA_W-1:0] root_base_reg;
    logic            q_valid;
    walk_item_t      q_item;
    logic            q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            root_base_reg <= cfg_wdata;
        end
    end

    ptw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    ptw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .root_base (root_base_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res       (res)
    );

endmodule

@@ rtl/ptw_checker.sv @@
// Port-level checks for the page table walker and their binding.
module ptw_checker
    import ptw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [KIND_W-1:0] res_kind,
    input logic [PA_W-1:0]   res_addr
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("Result valid dropped before the transfer.");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_kind) && $stable(res_addr))
        else $error("Result payload changed while stalled.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == KIND_READ || res_kind == KIND_DONE
                       || res_kind == KIND_FAULT))
        else $error("Result kind has an unused code.");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_FAULT |-> res_addr == '0)
        else $error("Fault result carries a nonzero address.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("Result valid during reset.");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.result_kind),
    .res_addr  (res.out_addr)
);

@@ bench/testbench.sv @@
// Self-checking testbench that drives random and directed page table walks through the walker.
module testbench
    import ptw_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 260;

    typedef struct {
        result_kind_t    kind;
        logic [PA_W-1:0] addr;
    } walk_result_t;

    class walk_scoreboard;
        logic [PA_W-1:0] root_base;
        bit              busy;
        level_t          level;
        logic [VA_W-1:0] held_va;
        walk_result_t    expected_q[$];
        int              failures;
        int              walk_items;

        function new();
            root_base  = '0;
            busy       = 1'b0;
            level      = LVL_TOP;
            held_va    = '0;
            failures   = 0;
            walk_items = 0;
        endfunction

        function logic [PA_W-1:0] entry_offset(level_t lvl);
            logic [VA_W-1:0] shifted;
            shifted = held_va >> (39 - 9 * int'(lvl));
            return PA_W'({shifted[IDX_W-1:0], 3'b000});
        endfunction

        function void push(result_kind_t kind, logic [PA_W-1:0] addr);
            expected_q.push_back('{kind: kind, addr: addr});
        endfunction

        function void end_walk();
            busy  = 1'b0;
            level = LVL_TOP;
        endfunction

        function void accept_item(op_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] entry);
            if (op == OP_TRANSLATE)
            begin
                held_va = va;
                level   = LVL_TOP;
                busy    = 1'b1;
                walk_items++;
                push(KIND_READ, root_base + entry_offset(LVL_TOP));
            end
            else if (busy)
            begin
                walk_items++;
                if (!entry[ENTRY_PRESENT_BIT])
                begin
                    end_walk();
                    push(KIND_FAULT, '0);
                end
                else if (level == LVL_MID && entry[ENTRY_LARGE_BIT])
                begin
                    end_walk();
                    push(KIND_DONE, {entry[PA_W-1:21], held_va[20:0]});
                end
                else if (level == LVL_LEAF)
                begin
                    end_walk();
                    push(KIND_DONE, {entry[PA_W-1:12], held_va[11:0]});
                end
                else
                begin
                    level = level_t'(level + 2'd1);
                    push(KIND_READ, {entry[PA_W-1:12], 12'h000} + entry_offset(level));
                end
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [PA_W-1:0] addr);
            walk_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result with none expected: result_kind %0d, out_addr %h", kind, addr);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (kind !== exp_r.kind)
            begin
                $error("result_kind mismatch: expected %0d, actual %0d", exp_r.kind, kind);
                failures++;
            end
            if (addr !== exp_r.addr)
            begin
                $error("out_addr mismatch: expected %h, actual %h", exp_r.addr, addr);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [PA_W-1:0] cfg_wdata;
    bit no_idle;
    walk_scoreboard sb;

    ptw_req_if req_ch();
    ptw_res_if res_ch();

    four_level_page_table_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(op_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.virt_addr <= va;
        req_ch.mem_data  <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.accept_item(op, va, data);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(logic [PA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.root_base = value;
    endtask

    task automatic run_walk();
        logic [VA_W-1:0] va;
        logic [PA_W-1:0] entry;
        int r;
        if ($urandom_range(0, 15) == 0)
            no_idle = !no_idle;
        if ($urandom_range(0, 9) == 0)
            send_item(OP_RESPONSE, VA_W'(rand64()), rand64());
        r = $urandom_range(0, 15);
        if (r == 0)
            va = '0;
        else if (r == 1)
            va = '1;
        else
            va = VA_W'(rand64());
        send_item(OP_TRANSLATE, va, rand64());
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                return;
            entry = rand64();
            entry[ENTRY_PRESENT_BIT] = (r >= 12);
            if (lvl == 2)
                entry[ENTRY_LARGE_BIT] = ($urandom_range(0, 3) == 0);
            send_item(OP_RESPONSE, VA_W'(rand64()), entry);
            if (!entry[ENTRY_PRESENT_BIT] || (lvl == 2 && entry[ENTRY_LARGE_BIT]))
                return;
        end
    endtask

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("** four_level_page_table_walker: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.result_kind, res_ch.out_addr);
            if (!rst_n)
                res_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [PA_W-1:0] roots[5];
        int start;
        sb               = new();
        no_idle          = 1'b0;
        rst_n            = 1'b1;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = OP_TRANSLATE;
        req_ch.virt_addr = '0;
        req_ch.mem_data  = '0;
        #1;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The root stays at its reset value for the directed walks.
        send_item(OP_RESPONSE, '1, '1);
        send_item(OP_TRANSLATE, '0, '0);
        send_item(OP_RESPONSE, '0, '1);
        send_item(OP_RESPONSE, '0, '1);
        send_item(OP_RESPONSE, '0, '1);
        send_item(OP_TRANSLATE, '1, '1);
        send_item(OP_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_F001);
        send_item(OP_RESPONSE, '0, 64'h8000_0000_0000_0001);
        send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0001);
        send_item(OP_RESPONSE, '0, '1);
        send_item(OP_TRANSLATE, 48'h8000_0000_0000, '0);
        send_item(OP_RESPONSE, '0, '0);
        send_item(OP_RESPONSE, '0, '0);
        send_item(OP_TRANSLATE, 48'h0000_0040_0000, '0);
        send_item(OP_RESPONSE, '0, 64'h0000_1234_5678_9081);
        send_item(OP_RESPONSE, '0, 64'h7FFF_0000_0000_0001);
        send_item(OP_TRANSLATE, 48'h5555_AAAA_5555, '0);
        send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0001);
        send_item(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_TRANSLATE, 48'hAAAA_5555_AAAA, '0);
        send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0081);
        send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0081);
        send_item(OP_RESPONSE, '0, 64'h0000_0000_0000_0001);
        send_item(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7E);
        drain();

        roots[0] = '1;
        roots[1] = rand64();
        roots[2] = '0;
        roots[3] = rand64() & ~64'hFFF;
        roots[4] = 64'hFFFF_FFFF_FFFF_F000;
        for (int p = 0; p < 5; p++)
        begin
            write_root(roots[p]);
            no_idle = p[0];
            start   = sb.walk_items;
            while (sb.walk_items - start < PHASE_ITEMS)
                run_walk();
            drain();
        end

        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("** four_level_page_table_walker: PASSED **");
        else
            $display("** four_level_page_table_walker: FAILED **");
        $finish;
    end

endmodule

@@ four_level_page_table_walker.f @@
rtl/ptw_pkg.sv
rtl/ptw_ifs.sv
rtl/ptw_front.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker.sv
rtl/ptw_checker.sv
bench/testbench.sv
